>>> design/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants and types for the min-priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int OCC_W    = 7;
   localparam int ST_W     = 2;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_out;
      logic [ST_W-1:0]          status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

endpackage

>>> design/mpq_slot_ram.sv
// ----------------------------------------------------------------------------
// mpq_slot_ram
// Slot value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpq_slot_ram (
   input  logic                        clock,
   input  mpq_pkg::ram_req_type        ram_req,
   output logic [mpq_pkg::DATA_W-1:0]  rd_data
);

   logic [mpq_pkg::DATA_W-1:0] mem_ff [mpq_pkg::CAPACITY];
   logic [mpq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[ram_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Request sequencer: occupancy bits, count, slot scan and min compare.
// ----------------------------------------------------------------------------
module mpq_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              req_op,
   input  logic signed [mpq_pkg::DATA_W-1:0] req_value,
   input  logic                              out_free,
   input  logic [mpq_pkg::DATA_W-1:0]        rd_data,
   output mpq_pkg::ram_req_type              ram_req,
   output logic                              idle,
   output logic                              rsp_load,
   output mpq_pkg::rsp_type                  rsp
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_LAST, S_FINISH} state_type;

   state_type                          state_ff;
   logic                               op_ff;
   logic signed [mpq_pkg::DATA_W-1:0]  value_ff;
   logic [mpq_pkg::IDX_W-1:0]          idx_ff;
   logic [mpq_pkg::CAPACITY-1:0]       valid_ff;
   logic [mpq_pkg::CNT_W-1:0]          count_ff;
   logic                               pipe_vld_ff;
   logic                               pipe_slot_vld_ff;
   logic [mpq_pkg::IDX_W-1:0]          pipe_idx_ff;
   logic                               found_ff;
   logic signed [mpq_pkg::DATA_W-1:0]  best_val_ff;
   logic [mpq_pkg::IDX_W-1:0]          best_idx_ff;
   logic [mpq_pkg::ST_W-1:0]           status_ff;

   logic                               commit;
   logic                               ok;
   logic [mpq_pkg::CNT_W-1:0]          count_in;

   assign idle     = (state_ff == S_IDLE);
   assign commit   = (state_ff == S_FINISH) && out_free;
   assign ok       = (status_ff == mpq_pkg::ST_OK);
   assign rsp_load = commit;

   always_comb begin
      count_in = count_ff;
      if (ok) begin
         if (op_ff == mpq_pkg::OP_INSERT) begin
            count_in = count_ff + 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   assign rsp.value_out = (op_ff == mpq_pkg::OP_EXTRACT && ok) ? best_val_ff : '0;
   assign rsp.status    = status_ff;
   assign rsp.occupancy = mpq_pkg::OCC_W'(count_in);

   assign ram_req.wr_en   = commit && ok && (op_ff == mpq_pkg::OP_INSERT);
   assign ram_req.wr_addr = best_idx_ff;
   assign ram_req.wr_data = value_ff;
   assign ram_req.rd_addr = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         valid_ff    <= '0;
         count_ff    <= '0;
         pipe_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         pipe_vld_ff      <= (state_ff == S_SCAN) && (op_ff == mpq_pkg::OP_EXTRACT);
         pipe_slot_vld_ff <= valid_ff[idx_ff];
         pipe_idx_ff      <= idx_ff;

         // min compare on the data returning from the store
         if (pipe_vld_ff && pipe_slot_vld_ff &&
             (!found_ff || $signed(rd_data) < best_val_ff)) begin
            best_val_ff <= $signed(rd_data);
            best_idx_ff <= pipe_idx_ff;
            found_ff    <= 1'b1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_op;
                  value_ff <= req_value;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  if (req_op == mpq_pkg::OP_EXTRACT && count_ff == '0) begin
                     status_ff <= mpq_pkg::ST_EMPTY;
                     state_ff  <= S_FINISH;
                  end else if (req_op == mpq_pkg::OP_INSERT &&
                               count_ff == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY)) begin
                     status_ff <= mpq_pkg::ST_FULL;
                     state_ff  <= S_FINISH;
                  end else begin
                     status_ff <= mpq_pkg::ST_OK;
                     state_ff  <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (op_ff == mpq_pkg::OP_INSERT) begin
                  if (!valid_ff[idx_ff]) begin
                     best_idx_ff <= idx_ff;
                     state_ff    <= S_FINISH;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end else begin
                  if (idx_ff == mpq_pkg::IDX_W'(mpq_pkg::CAPACITY - 1)) begin
                     state_ff <= S_LAST;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
               end
            end
            S_LAST: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               if (out_free) begin
                  if (ok) begin
                     valid_ff[best_idx_ff] <= (op_ff == mpq_pkg::OP_INSERT);
                  end
                  count_ff <= count_in;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == mpq_pkg::CNT_W'($countones(valid_ff)))
      else $error("count out of step with occupancy bits");

   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> !valid_ff[best_idx_ff])
      else $error("insert into occupied slot");

   a_extract_hit: assert property (@(posedge clock) disable iff (reset)
      (commit && ok && op_ff == mpq_pkg::OP_EXTRACT) |-> (found_ff && valid_ff[best_idx_ff]))
      else $error("extract of empty slot");

   a_pipe_from_scan: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff |-> $past(state_ff == S_SCAN))
      else $error("compare stage active outside scan");
`endif

endmodule

>>> design/min_priority_queue.sv
// ----------------------------------------------------------------------------
// min_priority_queue
// Min-priority queue of signed 32-bit values in an unordered slot store.
// ----------------------------------------------------------------------------
//   channel  dir  fields
//   req_*    in   tuser: op; tdata: value
//   rsp_*    out  tuser: status; tdata: value_out, occupancy
//
// Extract: one store read per slot, the registered read of the store, then
// writeback. Insert: a walk to the lowest free slot, then writeback.
// Empty or full requests go straight to writeback.
// Reset clears the occupancy bits and count.
// The next request is taken while a response waits; a stalled response
// holds the finished request in its writeback cycle.
module min_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value_out, [38:32] occupancy, [39] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   mpq_pkg::ram_req_type        ram_req;
   logic [mpq_pkg::DATA_W-1:0]  rd_data;
   logic                        idle;
   logic                        start;
   logic                        out_free;
   logic                        rsp_load;
   mpq_pkg::rsp_type            rsp;
   logic                        rsp_tvalid_ff;
   mpq_pkg::rsp_type            rsp_data_ff;

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   mpq_slot_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   mpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_tuser[0]),
      .req_value ($signed(req_tdata[31:0])),
      .out_free  (out_free),
      .rd_data   (rd_data),
      .ram_req   (ram_req),
      .idle      (idle),
      .rsp_load  (rsp_load),
      .rsp       (rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff.occupancy, rsp_data_ff.value_out};
   assign rsp_tuser  = rsp_data_ff.status;

endmodule
